@@ design/mcws_pkg.sv @@
package mcws_pkg;

  localparam int MAX_NODES  = 64;
  localparam int MAX_EDGES  = 8;

  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int EIDX_W     = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CNT_W      = $clog2(MAX_EDGES + 1);
  localparam int EDGE_DEPTH = MAX_NODES * (2 ** EIDX_W);
  localparam int SUM_W      = 17 + CNT_W;

  // item kinds
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_STEP  = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;

  // register index, taken from paddr[2]
  localparam logic REG_NODE_COUNT = 1'b0;

  localparam logic [6:0] NODE_COUNT_RESET = 7'd64;

  localparam logic signed [47:0] COST_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] COST_MIN = 48'sh8000_0000_0000;

  typedef struct packed {
    logic [1:0]         kind;
    logic [5:0]         source_node;
    logic [5:0]         target_node;
    logic [16:0]        edge_probability;
    logic signed [31:0] edge_cost;
    logic [15:0]        random_draw;
  } item_t;

  typedef struct packed {
    logic [5:0]         walker_node;
    logic signed [47:0] total_cost;
    logic               run_done;
    logic               moved;
    logic               load_rejected;
  } result_t;

  typedef struct packed {
    logic [5:0]         target;
    logic [16:0]        prob;
    logic signed [31:0] cost;
  } edge_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_RD,
    ST_LOAD_WR,
    ST_STEP_CHK,
    ST_SCAN,
    ST_APPLY,
    ST_SIMPLE
  } state_t;

  typedef struct packed {
    logic capture;
    logic cnt_rd;
    logic load_commit;
    logic scan_start;
    logic scan_en;
    logic apply;
    logic term_set;
    logic start_run;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       at_last;
    logic       pos_oob;
    logic       scan_hit;
    logic       scan_end;
  } dp_stat_t;

endpackage

@@ design/markov_cost_walk_step.sv @@
// channel  | ports                                  | beat taken when
// ---------+----------------------------------------+-----------------------------------
// item in  | start, busy, item                      | start high and busy low
// result   | done, result                           | done high (one cycle, no stall)
// config   | psel, penable, pwrite, paddr, pwdata,  | psel, penable, pwrite, pready high
//          | prdata, pready                         |
//
// per item: start or ignored kind pass the simple state; load reads the edge count, then
// writes; a step on the terminal node sets the flag; any other step reads the count, scans
// its stored edges and applies a hit; done is registered from the final state of each item
// the scan uses the single read port of the edge memory, one edge a cycle
// rst is synchronous and clears walker, cost, terminal flag and edge counts at once
// results cannot be held off; a new item may be taken while a result is on the ports
module markov_cost_walk_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  mcws_pkg::item_t     item,
  output logic                done,
  output mcws_pkg::result_t   result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import mcws_pkg::*;

  logic [6:0] node_count;
  ctrl_cmd_t  cmd;
  dp_stat_t   stat;

  // register file: node count only
  mcws_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .node_count (node_count)
  );

  // sequencer: load, step scan and run start
  mcws_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (item.kind),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // edge store, walker state, saturating cost and result register
  mcws_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .node_count (node_count),
    .cmd        (cmd),
    .stat       (stat),
    .done       (done),
    .result     (result)
  );

endmodule

@@ design/mcws_cfg.sv @@
module mcws_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [6:0]  node_count
);
  import mcws_pkg::*;

  logic wr_hit;

  // low address bits are the byte offset within the word
  assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_NODE_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RESET;
    end else if (wr_hit) begin
      node_count <= pwdata[6:0];
    end
  end

  assign prdata = (paddr[2] == REG_NODE_COUNT) ? {25'd0, node_count} : 32'd0;
  assign pready = 1'b1;

endmodule

@@ design/mcws_ctrl.sv @@
module mcws_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [1:0]           kind,
  input  mcws_pkg::dp_stat_t   stat,
  output mcws_pkg::ctrl_cmd_t  cmd,
  output logic                 busy
);
  import mcws_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          unique case (kind)
            KIND_LOAD: state_next = ST_LOAD_RD;
            KIND_STEP: state_next = ST_STEP_CHK;
            default:   state_next = ST_SIMPLE;
          endcase
        end
      end
      ST_LOAD_RD: begin
        cmd.cnt_rd = 1'b1;
        state_next = ST_LOAD_WR;
      end
      ST_LOAD_WR: begin
        cmd.load_commit = 1'b1;
        cmd.emit        = 1'b1;
        state_next      = ST_IDLE;
      end
      ST_STEP_CHK: begin
        if (stat.at_last) begin
          cmd.term_set = 1'b1;
          cmd.emit     = 1'b1;
          state_next   = ST_IDLE;
        end else if (stat.pos_oob) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.cnt_rd     = 1'b1;
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (stat.scan_hit) begin
          state_next = ST_APPLY;
        end else if (stat.scan_end) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_APPLY: begin
        cmd.apply  = 1'b1;
        cmd.emit   = 1'b1;
        state_next = ST_IDLE;
      end
      ST_SIMPLE: begin
        cmd.start_run = (stat.kind == KIND_START);
        cmd.emit      = 1'b1;
        state_next    = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/mcws_dp.sv @@
module mcws_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  mcws_pkg::item_t      item,
  input  logic [6:0]           node_count,
  input  mcws_pkg::ctrl_cmd_t  cmd,
  output mcws_pkg::dp_stat_t   stat,
  output logic                 done,
  output mcws_pkg::result_t    result
);
  import mcws_pkg::*;

  item_t              item_r;
  logic [5:0]         pos;
  logic signed [47:0] cost;
  logic               term;

  // edge store and per-node edge counts
  edge_t              edge_mem [EDGE_DEPTH];
  edge_t              edge_q;
  logic [CNT_W-1:0]   cnt_mem [MAX_NODES];
  logic [MAX_NODES-1:0] cnt_valid;
  logic [CNT_W-1:0]   cnt_q;

  // scan state
  logic [CNT_W-1:0]   idx;
  logic               pend;
  logic [SUM_W-1:0]   sum;

  logic [NODE_W-1:0]  src_row, pos_row, cnt_addr;
  logic [NODE_W+EIDX_W-1:0] wr_addr, rd_addr;
  logic               reject, issue, hit;
  logic [SUM_W-1:0]   sum_add;
  logic signed [48:0] cost_sum;
  logic signed [47:0] cost_sat;
  logic [5:0]         pos_next;
  logic signed [47:0] cost_next;
  logic               term_next;
  edge_t              wr_edge;

  assign src_row  = NODE_W'(item_r.source_node);
  assign pos_row  = NODE_W'(pos);
  assign cnt_addr = (item_r.kind == KIND_LOAD) ? src_row : pos_row;
  assign wr_addr  = {src_row, cnt_q[EIDX_W-1:0]};
  assign rd_addr  = {pos_row, idx[EIDX_W-1:0]};

  assign wr_edge.target = item_r.target_node;
  assign wr_edge.prob   = item_r.edge_probability;
  assign wr_edge.cost   = item_r.edge_cost;

  assign reject = ({1'b0, item_r.source_node} >= node_count)
               || (32'(item_r.source_node) >= 32'(MAX_NODES))
               || (cnt_q >= CNT_W'(MAX_EDGES));

  assign sum_add = sum + SUM_W'(edge_q.prob);
  assign hit     = pend && (SUM_W'(item_r.random_draw) <= sum_add);
  assign issue   = (idx < cnt_q) && !hit;

  assign stat.kind     = item_r.kind;
  assign stat.at_last  = ({1'b0, pos} == (node_count - 7'd1));
  assign stat.pos_oob  = (32'(pos) >= 32'(MAX_NODES));
  assign stat.scan_hit = hit;
  assign stat.scan_end = (idx >= cnt_q) && !hit;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= item;
    end
  end

  // count memory with valid bits, registered read
  always_ff @(posedge clk) begin
    if (cmd.load_commit && !reject) begin
      cnt_mem[src_row] <= cnt_q + CNT_W'(1);
    end
    if (cmd.cnt_rd) begin
      cnt_q <= cnt_valid[cnt_addr] ? cnt_mem[cnt_addr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_valid <= '0;
    end else if (cmd.load_commit && !reject) begin
      cnt_valid[src_row] <= 1'b1;
    end
  end

  // edge memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.load_commit && !reject) begin
      edge_mem[wr_addr] <= wr_edge;
    end
    if (cmd.scan_en && issue) begin
      edge_q <= edge_mem[rd_addr];
    end
  end

  // scan one stored edge per cycle; the check works on the registered read, flagged by pend
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      idx  <= '0;
      pend <= 1'b0;
      sum  <= '0;
    end else if (cmd.scan_en) begin
      if (issue) begin
        idx <= idx + CNT_W'(1);
      end
      pend <= issue;
      if (pend) begin
        sum <= sum_add;
      end
    end
  end

  always_comb begin
    cost_sum = {cost[47], cost} + {{17{edge_q.cost[31]}}, edge_q.cost};
    if (cost_sum[48] != cost_sum[47]) begin
      cost_sat = cost_sum[48] ? COST_MIN : COST_MAX;
    end else begin
      cost_sat = cost_sum[47:0];
    end
  end

  always_comb begin
    pos_next  = pos;
    cost_next = cost;
    term_next = term;
    if (cmd.start_run) begin
      pos_next  = '0;
      cost_next = '0;
      term_next = 1'b0;
    end else if (cmd.apply) begin
      pos_next  = edge_q.target;
      cost_next = cost_sat;
    end else if (cmd.term_set) begin
      term_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      cost <= '0;
      term <= 1'b0;
    end else begin
      pos  <= pos_next;
      cost <= cost_next;
      term <= term_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.walker_node   <= pos_next;
      result.total_cost    <= cost_next;
      result.run_done      <= term_next;
      result.moved         <= cmd.apply;
      result.load_rejected <= cmd.load_commit && reject;
    end
  end

endmodule

@@ design/mcws_chk.sv @@
module mcws_chk (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic pready
);

  // an accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting an item");

  // a result beat closes the work on an item
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && $past(busy)))
    else $error("result beat without finished item");

  // no result in the cycle right after acceptance
  a_no_early_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("result beat too early");

  // reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!busy && !done && pready))
    else $error("block not idle after reset");

endmodule

bind markov_cost_walk_step mcws_chk u_mcws_chk (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .pready (pready)
);
